[rtl/lpht_pkg.sv]
package lpht_pkg;

    // Storage geometry.
    localparam int TableDepth = 256;
    localparam int AddrW      = 8;
    localparam int SizeW      = 9;
    localparam int KeyW       = 64;
    localparam int HashW      = 32;
    localparam int ValW       = 32;
    localparam int LenW       = 4;
    localparam int OpW        = 2;

    // Longest key in bytes.
    localparam logic [LenW-1:0] KEY_BYTES = 4'd8;

    // The table size register comes out of reset at full depth.
    localparam logic [SizeW-1:0] SIZE_RESET = 9'd256;
    localparam logic [SizeW-1:0] SIZE_MAX   = 9'd256;
    localparam logic [SizeW-1:0] SIZE_MIN   = 9'd1;

    // Request opcodes.
    localparam logic [OpW-1:0] OP_PUT    = 2'd0;
    localparam logic [OpW-1:0] OP_GET    = 2'd1;
    localparam logic [OpW-1:0] OP_REMOVE = 2'd2;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_EXISTS    = 3'd2,
        ST_FULL      = 3'd3,
        ST_INVALID   = 3'd4
    } t_status;

    // Request sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_MOD,
        S_PROBE,
        S_RESP
    } t_state;

    // One stored slot.
    typedef struct packed {
        logic [LenW-1:0]  len;
        logic [KeyW-1:0]  key;
        logic [HashW-1:0] hash;
        logic [ValW-1:0]  value;
    } t_slot;

    // Write side of the slot store: fill a slot or free it.
    typedef struct packed {
        logic             wr_en;
        logic             clr_en;
        logic [AddrW-1:0] addr;
        t_slot            data;
    } t_ram_wr;

    // One result item.
    typedef struct packed {
        t_status         status;
        logic [ValW-1:0] value;
    } t_result;

endpackage

[rtl/lpht_mod_unit.sv]
module lpht_mod_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [lpht_pkg::HashW-1:0] i_dividend,
    input  logic [lpht_pkg::SizeW-1:0] i_divisor,
    output logic                       o_done,
    output logic [lpht_pkg::AddrW-1:0] o_rem
);

    // Restoring remainder, one dividend bit per cycle.
    logic                       r_busy;
    logic                       r_done;
    logic [4:0]                 r_cnt;
    logic [lpht_pkg::HashW-1:0] r_dvd;
    logic [lpht_pkg::SizeW-1:0] r_div;
    logic [lpht_pkg::AddrW-1:0] r_rem;

    logic [lpht_pkg::SizeW-1:0] trial;
    logic [lpht_pkg::SizeW-1:0] diff;

    // Shift in the next bit and subtract the divisor when it fits.
    always_comb begin
        trial = {r_rem, r_dvd[lpht_pkg::HashW-1]};
        diff  = trial - r_div;
    end

    // Control flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[lpht_pkg::HashW-2:0], 1'b0};
            if (trial >= r_div) begin
                r_rem <= diff[lpht_pkg::AddrW-1:0];
            end else begin
                r_rem <= trial[lpht_pkg::AddrW-1:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

[rtl/lpht_slot_ram.sv]
module lpht_slot_ram (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_rd_en,
    input  logic [lpht_pkg::AddrW-1:0] i_rd_addr,
    output lpht_pkg::t_slot            o_rd_data,
    output logic                       o_rd_used,
    input  lpht_pkg::t_ram_wr          i_wr
);

    // Slot payload; its contents only count where the used bit is set.
    lpht_pkg::t_slot r_mem [lpht_pkg::TableDepth];

    // One used bit per slot, cleared at reset.
    logic [lpht_pkg::TableDepth-1:0] r_used;

    lpht_pkg::t_slot r_rd_data;
    logic            r_rd_used;

    // Payload write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_wr.wr_en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // Used bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used    <= '0;
            r_rd_used <= 1'b0;
        end else begin
            if (i_wr.wr_en) begin
                r_used[i_wr.addr] <= 1'b1;
            end else if (i_wr.clr_en) begin
                r_used[i_wr.addr] <= 1'b0;
            end
            if (i_rd_en) begin
                r_rd_used <= r_used[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_rd_used = r_rd_used;

endmodule

[rtl/lpht_ctrl.sv]
module lpht_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // Configuration.
    input  logic                       i_cfg_we,
    input  logic [lpht_pkg::SizeW-1:0] i_cfg_wdata,
    // Request side.
    input  logic                       i_req_vld,
    output logic                       o_req_rdy,
    input  logic [lpht_pkg::OpW-1:0]   i_opcode,
    input  logic [lpht_pkg::LenW-1:0]  i_key_length,
    input  logic [lpht_pkg::KeyW-1:0]  i_key,
    input  logic [lpht_pkg::HashW-1:0] i_hash,
    input  logic [lpht_pkg::ValW-1:0]  i_value_in,
    // Result side.
    output logic                       o_res_vld,
    input  logic                       i_res_rdy,
    output lpht_pkg::t_result          o_res,
    // Remainder unit.
    output logic                       o_mod_start,
    output logic [lpht_pkg::HashW-1:0] o_mod_dividend,
    output logic [lpht_pkg::SizeW-1:0] o_mod_divisor,
    input  logic                       i_mod_done,
    input  logic [lpht_pkg::AddrW-1:0] i_mod_rem,
    // Slot store.
    output logic                       o_rd_en,
    output logic [lpht_pkg::AddrW-1:0] o_rd_addr,
    input  lpht_pkg::t_slot            i_rd_data,
    input  logic                       i_rd_used,
    output lpht_pkg::t_ram_wr          o_wr
);

    lpht_pkg::t_state r_state, n_state;

    logic [lpht_pkg::SizeW-1:0] r_cfg_size;

    // Request being served.
    logic [lpht_pkg::OpW-1:0]   r_op, n_op;
    logic [lpht_pkg::LenW-1:0]  r_len, n_len;
    logic [lpht_pkg::KeyW-1:0]  r_key, n_key;
    logic [lpht_pkg::HashW-1:0] r_hash, n_hash;
    logic [lpht_pkg::ValW-1:0]  r_val, n_val;
    logic [lpht_pkg::SizeW-1:0] r_size, n_size;
    lpht_pkg::t_result          r_res, n_res;

    // Probe pointers: one slot read is issued while the previous one is checked.
    logic [lpht_pkg::AddrW-1:0] r_rd_idx, n_rd_idx;
    logic [lpht_pkg::AddrW-1:0] r_cmp_idx, n_cmp_idx;
    logic                       r_cmp_vld, n_cmp_vld;
    logic [lpht_pkg::SizeW-1:0] r_issued, n_issued;
    logic [lpht_pkg::SizeW-1:0] r_checked, n_checked;

    logic [lpht_pkg::SizeW-1:0] act_size;
    logic [6:0]                 mask_sh;
    logic [lpht_pkg::KeyW-1:0]  key_mask;
    logic                       req_bad;
    logic [lpht_pkg::SizeW-1:0] idx_inc;
    logic                       hit;

    // Clamp the table size into one to full depth.
    always_comb begin
        if (r_cfg_size == '0) begin
            act_size = lpht_pkg::SIZE_MIN;
        end else if (r_cfg_size > lpht_pkg::SIZE_MAX) begin
            act_size = lpht_pkg::SIZE_MAX;
        end else begin
            act_size = r_cfg_size;
        end
    end

    // Keep only the key's low bytes; valid lengths are one to eight bytes.
    always_comb begin
        mask_sh  = {lpht_pkg::KEY_BYTES - i_key_length, 3'b000};
        key_mask = {lpht_pkg::KeyW{1'b1}} >> mask_sh;
        req_bad  = (i_key_length == '0) || (i_key_length > lpht_pkg::KEY_BYTES) ||
                   ((i_opcode != lpht_pkg::OP_PUT) && (i_opcode != lpht_pkg::OP_GET) &&
                    (i_opcode != lpht_pkg::OP_REMOVE));
    end

    // A slot hits when it is used and its hash, length and key all agree.
    always_comb begin
        idx_inc = {1'b0, r_rd_idx} + 9'd1;
        hit     = i_rd_used && (i_rd_data.len == r_len) &&
                  (i_rd_data.hash == r_hash) && (i_rd_data.key == r_key);
    end

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_size <= lpht_pkg::SIZE_RESET;
        end else if (i_cfg_we) begin
            r_cfg_size <= i_cfg_wdata;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= lpht_pkg::S_IDLE;
            r_cmp_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cmp_vld <= n_cmp_vld;
        end
    end

    // Payload and pointer registers.
    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_len     <= n_len;
        r_key     <= n_key;
        r_hash    <= n_hash;
        r_val     <= n_val;
        r_size    <= n_size;
        r_res     <= n_res;
        r_rd_idx  <= n_rd_idx;
        r_cmp_idx <= n_cmp_idx;
        r_issued  <= n_issued;
        r_checked <= n_checked;
    end

    // Sequencer: next state and outputs.
    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_len     = r_len;
        n_key     = r_key;
        n_hash    = r_hash;
        n_val     = r_val;
        n_size    = r_size;
        n_res     = r_res;
        n_rd_idx  = r_rd_idx;
        n_cmp_idx = r_cmp_idx;
        n_cmp_vld = 1'b0;
        n_issued  = r_issued;
        n_checked = r_checked;

        o_req_rdy      = 1'b0;
        o_res_vld      = 1'b0;
        o_mod_start    = 1'b0;
        o_mod_dividend = i_hash;
        o_mod_divisor  = act_size;
        o_rd_en        = 1'b0;
        o_rd_addr      = r_rd_idx;
        o_wr.wr_en     = 1'b0;
        o_wr.clr_en    = 1'b0;
        o_wr.addr      = r_cmp_idx;
        o_wr.data.len   = r_len;
        o_wr.data.key   = r_key;
        o_wr.data.hash  = r_hash;
        o_wr.data.value = r_val;

        case (r_state)
            lpht_pkg::S_IDLE: begin
                o_req_rdy = 1'b1;
                if (i_req_vld) begin
                    n_op   = i_opcode;
                    n_len  = i_key_length;
                    n_key  = i_key & key_mask;
                    n_hash = i_hash;
                    n_val  = i_value_in;
                    n_size = act_size;
                    if (req_bad) begin
                        n_res.status = lpht_pkg::ST_INVALID;
                        n_res.value  = '0;
                        n_state      = lpht_pkg::S_RESP;
                    end else begin
                        o_mod_start = 1'b1;
                        n_state     = lpht_pkg::S_MOD;
                    end
                end
            end

            // Wait for the start slot, hash modulo size.
            lpht_pkg::S_MOD: begin
                if (i_mod_done) begin
                    n_rd_idx  = i_mod_rem;
                    n_issued  = '0;
                    n_checked = '0;
                    n_state   = lpht_pkg::S_PROBE;
                end
            end

            lpht_pkg::S_PROBE: begin
                // Issue the next slot read while slots remain.
                if (r_issued != r_size) begin
                    o_rd_en   = 1'b1;
                    n_cmp_vld = 1'b1;
                    n_cmp_idx = r_rd_idx;
                    n_issued  = r_issued + 9'd1;
                    n_rd_idx  = (idx_inc == r_size) ? '0 : idx_inc[lpht_pkg::AddrW-1:0];
                end

                // Check the slot whose data has just arrived.
                if (r_cmp_vld) begin
                    n_checked = r_checked + 9'd1;
                    if (r_op == lpht_pkg::OP_PUT) begin
                        if (!i_rd_used) begin
                            o_wr.wr_en   = 1'b1;
                            n_res.status = lpht_pkg::ST_OK;
                            n_res.value  = '0;
                            n_state      = lpht_pkg::S_RESP;
                        end else if (hit) begin
                            n_res.status = lpht_pkg::ST_EXISTS;
                            n_res.value  = '0;
                            n_state      = lpht_pkg::S_RESP;
                        end else if (n_checked == r_size) begin
                            n_res.status = lpht_pkg::ST_FULL;
                            n_res.value  = '0;
                            n_state      = lpht_pkg::S_RESP;
                        end
                    end else begin
                        if (hit) begin
                            o_wr.clr_en  = (r_op == lpht_pkg::OP_REMOVE);
                            n_res.status = lpht_pkg::ST_OK;
                            n_res.value  = i_rd_data.value;
                            n_state      = lpht_pkg::S_RESP;
                        end else if (n_checked == r_size) begin
                            n_res.status = lpht_pkg::ST_NOT_FOUND;
                            n_res.value  = '0;
                            n_state      = lpht_pkg::S_RESP;
                        end
                    end
                    // A read still in flight is dropped once the probe ends.
                    if (n_state == lpht_pkg::S_RESP) begin
                        n_cmp_vld = 1'b0;
                    end
                end
            end

            lpht_pkg::S_RESP: begin
                o_res_vld = 1'b1;
                if (i_res_rdy) begin
                    n_state = lpht_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = lpht_pkg::S_IDLE;
            end
        endcase
    end

    assign o_res = r_res;

endmodule

[rtl/linear_probe_hash_table_unit.sv]
// Open-addressing hash table with linear probing.
// Input channel (s_axis): one request item per handshake, carrying opcode
// (put, get, remove), key length, key, the key's 32-bit hash and a value.
// Output channel (m_axis): one result item per request, carrying a status
// code and, on a successful get or remove, the stored value.
// Configuration: i_cfg_we writes the table size; write it only while idle.
// A request forms hash modulo size in a bit-serial remainder unit, then
// probes one slot per cycle through the slot store's registered read
// port; the worst case is a miss over the whole table. An invalid request
// skips the remainder unit and the probe and goes straight to its result.
// One request is served at a time; s_axis_tready is high only idle.
// The result sits in an output register, so the next request is accepted
// while it waits; if the receiver stalls, a second finished result waits
// inside the block until the register frees up.
// Reset empties every slot at once and sets the table size to 256.
module linear_probe_hash_table_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [lpht_pkg::SizeW-1:0] i_cfg_wdata,
    input  logic                       i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // opcode[1:0], key_length[5:2], key[69:6], hash[101:70], value_in[133:102]
    input  logic [135:0]               i_s_axis_tdata,
    output logic                       o_m_axis_tvalid,
    input  logic                       i_m_axis_tready,
    // status[2:0], value_out[34:3]
    output logic [39:0]                o_m_axis_tdata
);

    logic                       res_vld;
    logic                       res_rdy;
    lpht_pkg::t_result          res;
    logic                       mod_start;
    logic [lpht_pkg::HashW-1:0] mod_dividend;
    logic [lpht_pkg::SizeW-1:0] mod_divisor;
    logic                       mod_done;
    logic [lpht_pkg::AddrW-1:0] mod_rem;
    logic                       rd_en;
    logic [lpht_pkg::AddrW-1:0] rd_addr;
    lpht_pkg::t_slot            rd_data;
    logic                       rd_used;
    lpht_pkg::t_ram_wr          ram_wr;

    logic              r_out_vld;
    lpht_pkg::t_result r_out;

    lpht_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_req_vld      (i_s_axis_tvalid),
        .o_req_rdy      (o_s_axis_tready),
        .i_opcode       (i_s_axis_tdata[1:0]),
        .i_key_length   (i_s_axis_tdata[5:2]),
        .i_key          (i_s_axis_tdata[69:6]),
        .i_hash         (i_s_axis_tdata[101:70]),
        .i_value_in     (i_s_axis_tdata[133:102]),
        .o_res_vld      (res_vld),
        .i_res_rdy      (res_rdy),
        .o_res          (res),
        .o_mod_start    (mod_start),
        .o_mod_dividend (mod_dividend),
        .o_mod_divisor  (mod_divisor),
        .i_mod_done     (mod_done),
        .i_mod_rem      (mod_rem),
        .o_rd_en        (rd_en),
        .o_rd_addr      (rd_addr),
        .i_rd_data      (rd_data),
        .i_rd_used      (rd_used),
        .o_wr           (ram_wr)
    );

    lpht_mod_unit u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (mod_dividend),
        .i_divisor  (mod_divisor),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    lpht_slot_ram u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .o_rd_used (rd_used),
        .i_wr      (ram_wr)
    );

    // Output register: takes a result whenever it is empty or being drained.
    assign res_rdy = !r_out_vld || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res_vld && res_rdy) begin
            r_out_vld <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_vld && res_rdy) begin
            r_out <= res;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {5'b00000, r_out.value, r_out.status};

endmodule
